### sv/tbwp_pkg.sv
// Package for the tile background/window pixel unit: video memory geometry,
// register indexes, control bit positions and the shade-to-RGB table.
// No dependencies.
`default_nettype none

package tbwp_pkg;

  // Video memory geometry, split into an even-byte bank and an odd-byte bank
  localparam int VRAM_DEPTH = 8192;
  localparam int VRAM_AW    = $clog2(VRAM_DEPTH);
  localparam int BANK_DEPTH = VRAM_DEPTH / 2;
  localparam int BANK_AW    = VRAM_AW - 1;

  // Visible screen
  localparam int SCREEN_WIDTH = 160;
  localparam int LAST_LINE    = 143;

  // Tile map bases (offsets from 0x8000) and signed tile-data base (as a tile index)
  localparam logic [VRAM_AW-1:0] MAP_LOW_OFS      = VRAM_AW'(16'h1800);
  localparam logic [VRAM_AW-1:0] MAP_HIGH_OFS     = VRAM_AW'(16'h1C00);
  localparam logic [8:0]         TILES_SIGNED_IDX = 9'(16'h0800 >> 4);

  // Input item kinds
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_RENDER = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] REG_LCD_CONTROL = 3'd0;
  localparam logic [2:0] REG_SCROLL_Y    = 3'd1;
  localparam logic [2:0] REG_SCROLL_X    = 3'd2;
  localparam logic [2:0] REG_WINDOW_Y    = 3'd3;
  localparam logic [2:0] REG_WINDOW_X    = 3'd4;
  localparam logic [2:0] REG_BG_PALETTE  = 3'd5;

  // lcd_control bit positions
  localparam int LCDC_BG_EN    = 0;
  localparam int LCDC_BG_MAP   = 3;
  localparam int LCDC_TILE_SEL = 4;
  localparam int LCDC_WIN_EN   = 5;
  localparam int LCDC_WIN_MAP  = 6;

  // Reset values
  localparam logic [7:0] LCDC_RESET    = 8'd145;
  localparam logic [7:0] PALETTE_RESET = 8'd252;

  // Fixed color of each shade, {blue, green, red}
  function automatic logic [23:0] shade_rgb(input logic [1:0] shade);
    logic [23:0] rgb;
    case (shade)
      2'd0:    rgb = {8'd169, 8'd210, 8'd202};
      2'd1:    rgb = {8'd117, 8'd150, 8'd143};
      2'd2:    rgb = {8'd77,  8'd94,  8'd90};
      default: rgb = {8'd32,  8'd40,  8'd39};
    endcase
    return rgb;
  endfunction

endpackage

`default_nettype wire

### sv/tile_background_window_pixel.sv
// Top level of the tile background/window pixel unit: video memory banks,
// three-stage render pipeline and configuration registers.
// Depends on tbwp_pkg.
`default_nettype none

// Takes one request per clock unless stalled, write or render, and passes
// each rendered pixel through the map-byte registers, the tile-row registers
// and the output register. The map byte is read at accept, the tile row
// from that registered map byte as the pipeline advances, and the
// pixel/palette logic feeds the output register. The 8 KiB video memory is
// held as an even-byte and an odd-byte bank, each with one write port and two
// registered read ports, so both bit-plane bytes of a tile row come back in
// one read while the next request reads its map byte. Writes land at accept
// time and reads return the old byte on a same-cycle write, so requests see
// memory in request order. The pipeline only stalls while a finished pixel
// waits in the output register and another one is due behind it. Memory has
// no reset and no clearing pass. Config writes are taken at any time but act
// at once on requests already in flight, so make them while the unit is idle.
module tile_background_window_pixel
  import tbwp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Request channel
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // vram_address[12:0], vram_data[20:13],
                                      // line[28:21], column[36:29], zero pad
  input  wire logic        s_tuser,   // mode
  // Pixel channel
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [47:0] m_tdata,   // out_column[7:0], out_line[15:8],
                                      // shade[17:16], red[25:18],
                                      // green[33:26], blue[41:34], zero pad
  // Configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  // Request fields
  logic [VRAM_AW-1:0] vram_address;
  logic [7:0]         vram_data;
  logic [7:0]         line;
  logic [7:0]         column;

  assign vram_address = s_tdata[12:0];
  assign vram_data    = s_tdata[20:13];
  assign line         = s_tdata[28:21];
  assign column       = s_tdata[36:29];

  // Configuration registers
  logic [7:0] lcd_control;
  logic [7:0] scroll_y;
  logic [7:0] scroll_x;
  logic [7:0] window_y;
  logic [7:0] window_x;
  logic [7:0] bg_palette;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      lcd_control <= LCDC_RESET;
      scroll_y    <= '0;
      scroll_x    <= '0;
      window_y    <= '0;
      window_x    <= '0;
      bg_palette  <= PALETTE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LCD_CONTROL: lcd_control <= cfg_data;
        REG_SCROLL_Y:    scroll_y    <= cfg_data;
        REG_SCROLL_X:    scroll_x    <= cfg_data;
        REG_WINDOW_Y:    window_y    <= cfg_data;
        REG_WINDOW_X:    window_x    <= cfg_data;
        REG_BG_PALETTE:  bg_palette  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline control: stall only when a pixel is due and the output is full and not taken
  logic s1_valid;
  logic s2_valid;
  logic stall;
  logic advance;
  logic accept;

  assign stall    = s2_valid && m_tvalid && !m_tready;
  assign advance  = !stall;
  assign s_tready = !rst && advance;
  assign accept   = s_tvalid && s_tready;

  // Stage 0: window/background choice, coordinates and map address
  logic               in_window;
  logic [8:0]         col_plus7;
  logic [7:0]         xpos;
  logic [7:0]         ypos;
  logic               map_sel;
  logic [VRAM_AW-1:0] map_addr;
  logic               visible;

  always_comb begin
    col_plus7 = {1'b0, column} + 9'd7;
    in_window = lcd_control[LCDC_WIN_EN] && (window_y <= line) &&
                (col_plus7 >= {1'b0, window_x});
    if (in_window) begin
      xpos    = col_plus7[7:0] - window_x;
      ypos    = line - window_y;
      map_sel = lcd_control[LCDC_WIN_MAP];
    end else begin
      xpos    = column + scroll_x;
      ypos    = line + scroll_y;
      map_sel = lcd_control[LCDC_BG_MAP];
    end
    map_addr = (map_sel ? MAP_HIGH_OFS : MAP_LOW_OFS) |
               VRAM_AW'({ypos[7:3], xpos[7:3]});
    visible  = lcd_control[LCDC_BG_EN] && (line <= 8'(LAST_LINE)) &&
               ({1'b0, column} < 9'(SCREEN_WIDTH));
  end

  // Video memory banks
  logic [7:0] mem_even [BANK_DEPTH];
  logic [7:0] mem_odd  [BANK_DEPTH];

  logic               wr_en;
  logic [BANK_AW-1:0] wr_idx;
  logic [BANK_AW-1:0] map_idx;
  logic [BANK_AW-1:0] tile_idx;

  assign wr_en   = accept && (s_tuser == MODE_WRITE);
  assign wr_idx  = vram_address[VRAM_AW-1:1];
  assign map_idx = map_addr[VRAM_AW-1:1];

  logic [7:0] map_even_q;
  logic [7:0] map_odd_q;
  logic [7:0] lo_q;
  logic [7:0] hi_q;

  always_ff @(posedge clk) begin
    if (wr_en && !vram_address[0]) begin
      mem_even[wr_idx] <= vram_data;
    end
    if (wr_en && vram_address[0]) begin
      mem_odd[wr_idx] <= vram_data;
    end
    if (advance) begin
      map_even_q <= mem_even[map_idx];
      map_odd_q  <= mem_odd[map_idx];
      lo_q       <= mem_even[tile_idx];
      hi_q       <= mem_odd[tile_idx];
    end
  end

  // Stage 1 registers: map byte in flight
  logic       s1_map_odd;
  logic [2:0] s1_x;
  logic [2:0] s1_y;
  logic [7:0] s1_line;
  logic [7:0] s1_column;

  // Stage 2 registers: tile row in flight
  logic [2:0] s2_x;
  logic [7:0] s2_line;
  logic [7:0] s2_column;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept && (s_tuser == MODE_RENDER) && visible;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_map_odd <= map_addr[0];
      s1_x       <= xpos[2:0];
      s1_y       <= ypos[2:0];
      s1_line    <= line;
      s1_column  <= column;
      s2_x       <= s1_x;
      s2_line    <= s1_line;
      s2_column  <= s1_column;
    end
  end

  // Stage 1: tile number to tile-row index (unsigned or signed addressing)
  logic [7:0] tile;
  logic [8:0] tile_num;

  always_comb begin
    tile = s1_map_odd ? map_odd_q : map_even_q;
    if (lcd_control[LCDC_TILE_SEL]) begin
      tile_num = {1'b0, tile};
    end else begin
      tile_num = TILES_SIGNED_IDX + {1'b0, tile ^ 8'h80};
    end
    tile_idx = BANK_AW'({tile_num, s1_y});
  end

  // Stage 2: pixel bits, palette, color
  logic [2:0]  bit_sel;
  logic [1:0]  pix;
  logic [1:0]  shade;
  logic [23:0] rgb;

  always_comb begin
    bit_sel = 3'd7 - s2_x;
    pix     = {hi_q[bit_sel], lo_q[bit_sel]};
    shade   = bg_palette[{pix, 1'b0} +: 2];
    rgb     = shade_rgb(shade);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && s2_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s2_valid) begin
      m_tdata <= {6'd0, rgb, shade, s2_line, s2_column};
    end
  end

`ifndef SYNTH
  // A pixel due behind a full, stalled output blocks new requests
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && m_tvalid && !m_tready) |-> !s_tready)
    else $error("request accepted while pipeline stalled");

  // A pixel leaving the last stage shows up at the output next cycle
  a_pixel_delivered: assert property (@(posedge clk) disable iff (rst)
    (advance && s2_valid) |=> m_tvalid)
    else $error("rendered pixel lost");

  // Only visible positions are ever delivered
  a_visible_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:8] <= 8'(LAST_LINE)) &&
                 ({1'b0, m_tdata[7:0]} < 9'(SCREEN_WIDTH)))
    else $error("pixel outside the screen delivered");
`endif

endmodule

`default_nettype wire

### tb/sv/tile_background_window_pixel_test.sv
// Self-checking test of the tile background/window pixel unit: video memory
// loads, render requests and register settings against an in-bench predictor.
// Depends on tbwp_pkg and tile_background_window_pixel.
module tile_background_window_pixel_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tbwp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 850;
  localparam logic [12:0] TILES_SIGNED_BASE = 13'h0800;

  // One rendered pixel as it leaves the block
  typedef struct packed {
    logic [7:0] column;
    logic [7:0] line;
    logic [1:0] shade;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // Shadow of memory and registers; queues the pixels each render must give
  class pixel_scoreboard;
    logic [7:0] vram [VRAM_DEPTH];
    bit written [VRAM_DEPTH];
    logic [7:0] lcdc, scy, scx, wy, wx, bgp;
    pixel_t pixels_due[$];
    int errors;

    function new();
      lcdc = LCDC_RESET;
      scy = 8'd0;
      scx = 8'd0;
      wy = 8'd0;
      wx = 8'd0;
      bgp = PALETTE_RESET;
      errors = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    function void set_reg(logic [2:0] idx, logic [7:0] val);
      case (idx)
        REG_LCD_CONTROL: lcdc = val;
        REG_SCROLL_Y:    scy = val;
        REG_SCROLL_X:    scx = val;
        REG_WINDOW_Y:    wy = val;
        REG_WINDOW_X:    wx = val;
        REG_BG_PALETTE:  bgp = val;
        default: ;
      endcase
    endfunction

    function bit visible(logic [7:0] ln, logic [7:0] col);
      return lcdc[LCDC_BG_EN] && ln <= LAST_LINE && col < SCREEN_WIDTH;
    endfunction

    // Map byte address and in-map coordinates; window wins from its column on
    function void locate(input logic [7:0] ln, input logic [7:0] col,
                         output logic [12:0] map_a, output logic [7:0] xpos,
                         output logic [7:0] ypos);
      bit win;
      logic [12:0] base;
      win = lcdc[LCDC_WIN_EN] && wy <= ln && ({1'b0, col} + 9'd7) >= {1'b0, wx};
      if (win) begin
        xpos = col + 8'd7 - wx;
        ypos = ln - wy;
        base = lcdc[LCDC_WIN_MAP] ? MAP_HIGH_OFS : MAP_LOW_OFS;
      end else begin
        xpos = col + scx;
        ypos = ln + scy;
        base = lcdc[LCDC_BG_MAP] ? MAP_HIGH_OFS : MAP_LOW_OFS;
      end
      map_a = base + {3'b0, ypos[7:3], xpos[7:3]};
    endfunction

    // Address of the low bit-plane byte of the tile row; high plane follows
    function logic [12:0] row_addr(logic [7:0] tile, logic [7:0] ypos);
      logic [12:0] tile_a;
      if (lcdc[LCDC_TILE_SEL])
        tile_a = {1'b0, tile, 4'b0};
      else
        tile_a = TILES_SIGNED_BASE + {1'b0, tile ^ 8'h80, 4'b0};
      return tile_a + {9'b0, ypos[2:0], 1'b0};
    endfunction

    function logic [23:0] shade_color(logic [1:0] s);
      case (s)
        2'd0:    return {8'd202, 8'd210, 8'd169};
        2'd1:    return {8'd143, 8'd150, 8'd117};
        2'd2:    return {8'd90, 8'd94, 8'd77};
        default: return {8'd39, 8'd40, 8'd32};
      endcase
    endfunction

    // Called once per accepted request, in acceptance order
    function void note_request(logic mode, logic [12:0] addr, logic [7:0] data,
                               logic [7:0] ln, logic [7:0] col);
      logic [12:0] map_a, row_a;
      logic [7:0] xpos, ypos, lo, hi;
      logic [2:0] bsel;
      logic [1:0] pix;
      pixel_t p;
      if (mode == MODE_WRITE) begin
        vram[addr] = data;
        written[addr] = 1'b1;
        return;
      end
      if (!visible(ln, col))
        return;
      locate(ln, col, map_a, xpos, ypos);
      row_a = row_addr(vram[map_a], ypos);
      lo = vram[row_a];
      hi = vram[row_a + 13'd1];
      bsel = 3'd7 - xpos[2:0];
      pix = {hi[bsel], lo[bsel]};
      p.column = col;
      p.line = ln;
      p.shade = 2'(bgp >> {pix, 1'b0});
      {p.red, p.green, p.blue} = shade_color(p.shade);
      pixels_due.push_back(p);
    endfunction

    task check_field(string name, logic [7:0] got, logic [7:0] want, pixel_t p);
      if (got !== want)
        report($sformatf("%s at line %0d column %0d: got %0d, expected %0d",
                         name, p.line, p.column, got, want));
    endtask

    task check_pixel(logic [47:0] d);
      pixel_t want;
      if (pixels_due.size() == 0) begin
        report($sformatf("pixel line %0d column %0d with none pending",
                         d[15:8], d[7:0]));
        return;
      end
      want = pixels_due.pop_front();
      check_field("column", d[7:0], want.column, want);
      check_field("line", d[15:8], want.line, want);
      check_field("shade", {6'b0, d[17:16]}, {6'b0, want.shade}, want);
      check_field("red", d[25:18], want.red, want);
      check_field("green", d[33:26], want.green, want);
      check_field("blue", d[41:34], want.blue, want);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // vram_address, vram_data, line, column, pad
  logic        s_tuser = MODE_WRITE;   // mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // out_column, out_line, shade, red, green, blue, pad
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_LCD_CONTROL;
  logic [7:0]  cfg_data = '0;

  pixel_scoreboard sb;
  int cycles = 0;
  int items_sent = 0;
  int rx_mode = 0;
  int stall_left = 0;
  bit burst = 1'b0;
  bit have_last = 1'b0;
  logic [7:0] last_ln = '0;
  logic [7:0] last_col = '0;

  tile_background_window_pixel u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tile_background_window_pixel_test NOT OK");
      $finish;
    end
  end

  // Receiver back-pressure, style chosen per phase
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      case (rx_mode)
        1: if ($urandom_range(0, 99) < 30) stall_left <= $urandom_range(1, 3);
        2: if ($urandom_range(0, 99) < 4) stall_left <= $urandom_range(10, 40);
        default: ;
      endcase
    end
  end

  // Pixel monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_pixel(m_tdata);
  end

  // Sender gap: mostly none or short, now and then long
  task automatic pause_sender();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60)
      return;
    s_tvalid <= 1'b0;
    if (r < 93)
      repeat ($urandom_range(1, 3)) @(posedge clk);
    else
      repeat ($urandom_range(8, 40)) @(posedge clk);
  endtask

  task automatic send(logic mode, logic [12:0] addr, logic [7:0] data,
                      logic [7:0] ln, logic [7:0] col);
    pause_sender();
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {3'b0, col, ln, data, addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(mode, addr, data, ln, col);
    items_sent++;
  endtask

  task automatic write_byte(logic [12:0] addr);
    send(MODE_WRITE, addr, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic fill(logic [12:0] addr);
    if (!sb.written[addr])
      write_byte(addr);
  endtask

  // Render request, preceded by writes of any byte it would read unwritten
  task automatic render_at(logic [7:0] ln, logic [7:0] col);
    logic [12:0] map_a, row_a;
    logic [7:0] xpos, ypos;
    if (sb.visible(ln, col)) begin
      sb.locate(ln, col, map_a, xpos, ypos);
      fill(map_a);
      row_a = sb.row_addr(sb.vram[map_a], ypos);
      fill(row_a);
      fill(row_a + 13'd1);
      last_ln = ln;
      last_col = col;
      have_last = 1'b1;
    end
    send(MODE_RENDER, 13'($urandom), 8'($urandom), ln, col);
  endtask

  // Overwrite one byte the last pixel used, then render it again right away
  task automatic rewrite_and_rerender();
    logic [12:0] map_a, row_a;
    logic [7:0] xpos, ypos;
    if (sb.visible(last_ln, last_col)) begin
      sb.locate(last_ln, last_col, map_a, xpos, ypos);
      row_a = sb.row_addr(sb.vram[map_a], ypos);
      case ($urandom_range(0, 2))
        0:       write_byte(map_a);
        1:       write_byte(row_a);
        default: write_byte(row_a + 13'd1);
      endcase
    end
    render_at(last_ln, last_col);
  endtask

  // Wait until every pixel is out and the pipeline has emptied
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pixels_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic load_config(logic [7:0] lcdc, logic [7:0] scy, logic [7:0] scx,
                             logic [7:0] wy, logic [7:0] wx, logic [7:0] bgp);
    drain();
    write_reg(REG_LCD_CONTROL, lcdc);
    write_reg(REG_SCROLL_Y, scy);
    write_reg(REG_SCROLL_X, scx);
    write_reg(REG_WINDOW_Y, wy);
    write_reg(REG_WINDOW_X, wx);
    write_reg(REG_BG_PALETTE, bgp);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    int phase;
    int r;
    int n;
    logic [7:0] lcdc, wy, wx;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: address and data extremes, screen corners, off-screen lines
    write_byte(13'h1FFF);
    send(MODE_WRITE, 13'h1FFF, 8'hFF, 8'h00, 8'h00);
    send(MODE_WRITE, 13'h0000, 8'h00, 8'hFF, 8'hFF);
    render_at(8'd0, 8'd0);
    render_at(8'(LAST_LINE), 8'(SCREEN_WIDTH - 1));
    render_at(8'(LAST_LINE + 1), 8'd0);
    render_at(8'hFF, 8'(SCREEN_WIDTH - 1));

    // Window from column 0 with window_x below 7, high maps, full scroll
    load_config(8'hFF, 8'hFF, 8'hFF, 8'd0, 8'd3, 8'hE4);
    render_at(8'd0, 8'd0);
    render_at(8'd10, 8'd100);

    // Signed tile data; background left of the window and above it
    load_config(8'h21, 8'h80, 8'h10, 8'd20, 8'd87, 8'h1B);
    render_at(8'd30, 8'd10);
    render_at(8'd30, 8'd79);
    render_at(8'd30, 8'd80);
    render_at(8'd10, 8'd100);
    render_at(8'(LAST_LINE), 8'(SCREEN_WIDTH - 1));

    // Background disabled: nothing comes out
    load_config(8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'hE4);
    render_at(8'd5, 8'd5);

    // Random phases, each under its own register setting
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase == 0) begin
        load_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      end else if (phase == 1) begin
        load_config(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      end else begin
        lcdc = pick_value();
        if ($urandom_range(0, 9) != 0) lcdc[LCDC_BG_EN] = 1'b1;
        wy = ($urandom_range(0, 3) == 0) ? pick_value() : 8'($urandom_range(0, LAST_LINE));
        wx = ($urandom_range(0, 3) == 0) ? pick_value() : 8'($urandom_range(0, 166));
        load_config(lcdc, pick_value(), pick_value(), wy, wx, pick_value());
      end
      rx_mode <= $urandom_range(0, 2);
      burst = ($urandom_range(0, 3) == 0);
      n = $urandom_range(40, 100);
      while (n > 0 && items_sent < ITEM_TARGET) begin
        r = $urandom_range(0, 99);
        if (r < 55)
          render_at(8'($urandom_range(0, LAST_LINE)), 8'($urandom_range(0, SCREEN_WIDTH - 1)));
        else if (r < 70 && have_last)
          rewrite_and_rerender();
        else if (r < 82)
          send(MODE_WRITE, 13'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        else if (r < 93 && have_last)
          render_at(last_ln, (last_col < SCREEN_WIDTH - 1) ? last_col + 8'd1 : 8'd0);
        else
          render_at(8'($urandom), 8'($urandom));
        n--;
      end
      phase++;
    end

    drain();
    if (sb.errors == 0 && sb.pixels_due.size() == 0)
      $display("tile_background_window_pixel_test OK");
    else
      $display("tile_background_window_pixel_test NOT OK");
    $finish;
  end

endmodule

### tile_background_window_pixel.f
sv/tbwp_pkg.sv
sv/tile_background_window_pixel.sv
tb/sv/tile_background_window_pixel_test.sv
